[sv/spl_pkg.sv]
// Shared types and constants for the sorted point list.
// No dependencies; used by spl_cell and sorted_point_list_core.
`default_nettype none

package spl_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic        [1:0]  command;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [31:0] key_value;
	} req_t;

	typedef struct packed {
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic               is_empty;
		logic        [6:0]  entry_count;
		logic               overflow;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} entry_t;

	typedef struct packed {
		logic ld;     // insert request accepted this cycle
		logic valid;  // this slot holds an entry
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/spl_cell.sv]
// One slot of the sorted chain: holds an entry, compares it with the new key,
// and keeps, takes the new entry, or takes its left neighbor. Uses spl_pkg.
`default_nettype none

module spl_cell (
	input  wire logic              clk,
	input  wire spl_pkg::cell_ctl_t ctl,
	input  wire spl_pkg::entry_t   new_entry,
	input  wire spl_pkg::entry_t   left_entry,
	input  wire logic              left_gt,
	output spl_pkg::entry_t        entry,
	output logic                   gt
);

	spl_pkg::entry_t entry_q;

	// stored key strictly above the new key: entry stays in place
	assign gt    = ctl.valid && (new_entry.key < entry_q.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ld && !gt) begin
			if (left_gt) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

endmodule

`default_nettype wire

[sv/sorted_point_list_core.sv]
// Top level of the sorted point list: a row of spl_cell slots plus occupancy
// and result registers. Depends on spl_pkg and spl_cell.
`default_nettype none

// Sorted point list. Holds up to spl_pkg::CAPACITY points ordered by signed
// Q16.16 key, largest first; equal keys put the newest first. Each request
// (insert, clear, query; code 3 acts as query) yields one response with the
// largest- and smallest-key points (zero when empty), the count, an empty
// flag and an overflow flag. When full, an insert drops whichever entry ends
// up last, possibly the new point. Rate: one request per cycle, but a
// response waiting on a stalled output blocks new requests. Response in the
// cycle after acceptance; every slot compares its key with the new key in
// parallel and shifts right by one in the same cycle, so the row of slots
// sets the pace. Only occupancy and response valid reset: no clearing pass.

module sorted_point_list_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire spl_pkg::req_t cmd_data,
	output logic               res_valid,
	input  wire logic          res_stall,
	output spl_pkg::rsp_t      res_data
);

	localparam int CAP = spl_pkg::CAPACITY;

	logic [spl_pkg::CNT_W-1:0] occ_q, occ_next;
	logic                      res_valid_q;
	spl_pkg::rsp_t             res_q;
	spl_pkg::entry_t           min_q, min_next;
	spl_pkg::entry_t           max_next;

	spl_pkg::entry_t           new_entry;
	spl_pkg::entry_t           cell_entry [CAP];
	logic [CAP-1:0]            gt;
	logic [CAP-1:0]            valid;

	logic accept, do_insert, do_clear, full, below_all;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = res_valid_q && res_stall;

	always_comb begin
		do_insert = 1'b0;
		do_clear  = 1'b0;
		unique case (cmd_data.command)
			spl_pkg::CMD_INSERT: do_insert = 1'b1;
			spl_pkg::CMD_CLEAR:  do_clear  = 1'b1;
			default: ;  // query, and the unused code
		endcase
	end

	assign new_entry.key = cmd_data.key_value;
	assign new_entry.x   = cmd_data.point_x;
	assign new_entry.y   = cmd_data.point_y;

	assign full = (occ_q == spl_pkg::CNT_W'(CAP));

	// chain of slots; slot 0 has the new entry to its left
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		spl_pkg::cell_ctl_t ctl;
		assign valid[i]  = (occ_q > spl_pkg::CNT_W'(i));
		assign ctl.valid = valid[i];
		assign ctl.ld    = accept && do_insert;
		if (i == 0) begin : g_head
			spl_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.new_entry (new_entry),
				.left_entry(new_entry),
				.left_gt   (1'b1),
				.entry     (cell_entry[i]),
				.gt        (gt[i])
			);
		end else begin : g_body
			spl_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.new_entry (new_entry),
				.left_entry(cell_entry[i-1]),
				.left_gt   (gt[i-1]),
				.entry     (cell_entry[i]),
				.gt        (gt[i])
			);
		end
	end

	// new key falls below every stored key (or list empty)
	assign below_all = &(gt | ~valid);

	always_comb begin
		occ_next = occ_q;
		max_next = cell_entry[0];
		min_next = min_q;
		if (do_clear) begin
			occ_next = '0;
		end else if (do_insert) begin
			if (!full) begin
				occ_next = occ_q + 1'b1;
			end
			if (!gt[0]) begin
				max_next = new_entry;
			end
			if (full) begin
				// last slot: keeps its own entry, takes new, or takes its left one
				if (!below_all) begin
					min_next = gt[CAP-2] ? new_entry : cell_entry[CAP-2];
				end
			end else if (below_all) begin
				min_next = new_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_next;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			min_q                <= min_next;
			res_q.is_empty       <= (occ_next == '0);
			res_q.entry_count    <= 7'(occ_next);
			res_q.overflow       <= do_insert && full;
			if (occ_next == '0) begin
				res_q.max_x <= '0;
				res_q.max_y <= '0;
				res_q.min_x <= '0;
				res_q.min_y <= '0;
			end else begin
				res_q.max_x <= max_next.x;
				res_q.max_y <= max_next.y;
				res_q.min_x <= min_next.x;
				res_q.min_y <= min_next.y;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// stay flags form a prefix of the row: the list stays sorted
	a_gt_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((gt >> 1) & ~gt) == '0)
		else $error("slot compare flags not a prefix");

	// occupancy never exceeds capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= spl_pkg::CNT_W'(CAP))
		else $error("occupancy above capacity");

	// overflow only reported with the list full, and not empty
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.overflow |-> !res_data.is_empty && full)
		else $error("overflow without full list");

	// an accepted request yields a response on the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid && (res_data.is_empty == (occ_q == '0)))
		else $error("response missing after accepted request");

endmodule

`default_nettype wire
